>>> rtl/egd_pkg.sv
// shared types and constants of the elevator group dispatcher
package egd_pkg;

  // input request kinds as they arrive on the mode field
  localparam logic [1:0] MODE_HEARTBEAT = 2'd0;
  localparam logic [1:0] MODE_STATUS    = 2'd1;
  localparam logic [1:0] MODE_HALL_CALL = 2'd2;
  localparam logic [1:0] MODE_TICK      = 2'd3;

  // motion and car mode codes
  localparam logic [1:0] MOTION_UP   = 2'd1;
  localparam logic [1:0] MOTION_DOWN = 2'd2;
  localparam logic [1:0] CAR_IDLE    = 2'd0;
  localparam logic [1:0] CAR_MOVING  = 2'd1;
  localparam logic [1:0] CAR_FAULT   = 2'd2;

  localparam logic [7:0]  AWAY_PENALTY    = 8'd2;
  localparam logic [7:0]  NO_CAR_COST     = 8'hFF;
  localparam logic [31:0] TIMEOUT_RST_VAL = 32'd1000;

  // classified command passed from front to back
  typedef enum logic [2:0] {
    CMD_HEARTBEAT,
    CMD_STATUS,
    CMD_HALL_UP,
    CMD_HALL_DOWN,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  node;      // car index, id minus one
    logic [7:0]  floor;     // car floor, or clamped hall call floor
    logic [1:0]  motion;
    logic [1:0]  car_mode;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [3:0] assign_node;
    logic [4:0] assign_floor;
    logic [1:0] assign_direction;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_FIND,
    ST_COST,
    ST_EMIT
  } back_st_t;

endpackage

>>> rtl/egd_fifo.sv
// small first-in first-out queue of registers
module egd_fifo
  import egd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/egd_front.sv
// front end: decodes and filters incoming requests into commands
module egd_front
  import egd_pkg::*;
#(
  parameter int NODE_COUNT = 8,
  parameter int TOP_FLOOR  = 31
) (
  input  logic        in_push,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_node_id,
  input  logic [7:0]  in_floor,
  input  logic [1:0]  in_direction,
  input  logic [1:0]  in_car_mode,
  input  logic [31:0] in_now_ms,
  output logic        cmd_push,
  output cmd_t        cmd
);

  logic id_ok;
  logic keep;

  assign id_ok = (in_node_id != 4'd0) && (in_node_id <= 4'(NODE_COUNT));

  always_comb begin
    cmd.node     = in_node_id - 4'd1;
    cmd.floor    = in_floor;
    cmd.motion   = in_direction;
    cmd.car_mode = in_car_mode;
    cmd.now_ms   = in_now_ms;
    keep         = 1'b1;
    case (in_mode)
      MODE_HEARTBEAT: begin
        cmd.kind = CMD_HEARTBEAT;
        keep     = id_ok;
      end
      MODE_STATUS: begin
        cmd.kind = CMD_STATUS;
        keep     = id_ok;
      end
      MODE_HALL_CALL: begin
        cmd.kind  = (in_direction == MOTION_DOWN) ? CMD_HALL_DOWN : CMD_HALL_UP;
        cmd.floor = (in_floor > 8'(TOP_FLOOR)) ? 8'(TOP_FLOOR) : in_floor;
      end
      default: begin
        cmd.kind = CMD_TICK;
      end
    endcase
  end

  // bad car ids on heartbeats and status reports are taken and dropped here
  assign cmd_push = in_push && keep;

endmodule

>>> rtl/egd_back.sv
// back end: car table, pending call masks and the tick sequencer
module egd_back
  import egd_pkg::*;
#(
  parameter int NODE_COUNT = 8,
  parameter int TOP_FLOOR  = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic        cmd_empty,
  output logic        cmd_pop,
  input  logic [31:0] timeout,
  input  logic        res_full,
  output logic        res_push,
  output res_t        res
);

  localparam int IDX_W   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int FLOOR_N = TOP_FLOOR + 1;
  localparam int FW      = $clog2(FLOOR_N);

  back_st_t state_r, state_nxt;

  logic [IDX_W-1:0]   idx_r;
  logic [31:0]        now_r;
  logic [FW-1:0]      call_floor_r;
  logic               call_down_r;
  logic [3:0]         best_id_r;
  logic [7:0]         min_cost_r;
  logic               online_r    [NODE_COUNT];
  logic [31:0]        last_seen_r [NODE_COUNT];
  logic [7:0]         floor_r     [NODE_COUNT];
  logic [1:0]         motion_r    [NODE_COUNT];
  logic [1:0]         cstate_r    [NODE_COUNT];
  logic [FLOOR_N-1:0] pend_up_r, pend_down_r;

  logic               idx_last;
  logic [FW-1:0]      cmd_fidx;
  logic [IDX_W-1:0]   cmd_idx;
  logic [31:0]        elapsed;
  logic               expire_hit;
  logic [FLOOR_N-1:0] pend_any;
  logic [FW-1:0]      low_floor;
  logic [7:0]         cf, fl8, span, cost;
  logic               away, candidate, take;
  logic               start_tick;

  assign idx_last = (idx_r == IDX_W'(NODE_COUNT - 1));
  assign cmd_fidx = cmd.floor[FW-1:0];
  assign cmd_idx  = cmd.node[IDX_W-1:0];

  // silence check on the car under the sweep index
  assign elapsed    = now_r - last_seen_r[idx_r];
  assign expire_hit = online_r[idx_r] && (elapsed > timeout);

  // lowest pending floor, up or down
  assign pend_any = pend_up_r | pend_down_r;
  always_comb begin
    low_floor = '0;
    for (int i = FLOOR_N - 1; i >= 0; i--) begin
      if (pend_any[i]) begin
        low_floor = FW'(i);
      end
    end
  end

  // cost of the car under the sweep index
  assign cf   = floor_r[idx_r];
  assign fl8  = 8'(call_floor_r);
  assign span = (cf > fl8) ? (cf - fl8) : (fl8 - cf);
  assign away = ((motion_r[idx_r] == MOTION_UP) && (cf > fl8)) ||
                ((motion_r[idx_r] == MOTION_DOWN) && (cf < fl8));
  assign cost = span + (((cstate_r[idx_r] == CAR_MOVING) && away) ? AWAY_PENALTY : 8'd0);
  assign candidate = online_r[idx_r] && (cstate_r[idx_r] != CAR_FAULT);
  assign take      = candidate && (cost < min_cost_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty && (cmd.kind == CMD_TICK) && !res_full) begin
          state_nxt = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        if (idx_last) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        state_nxt = (pend_any != '0) ? ST_COST : ST_IDLE;
      end
      ST_COST: begin
        if (idx_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop    = 1'b0;
    start_tick = 1'b0;
    res_push   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.kind == CMD_TICK) begin
            start_tick = !res_full;
            cmd_pop    = !res_full;
          end else begin
            cmd_pop = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        res_push = (best_id_r != 4'd0);
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  assign res.assign_node      = best_id_r;
  assign res.assign_floor     = 5'(call_floor_r);
  assign res.assign_direction = call_down_r ? MOTION_DOWN : MOTION_UP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // car table and call masks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_up_r   <= '0;
      pend_down_r <= '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        online_r[i]    <= 1'b0;
        last_seen_r[i] <= '0;
        floor_r[i]     <= '0;
        motion_r[i]    <= '0;
        cstate_r[i]    <= CAR_IDLE;
      end
    end else begin
      if (cmd_pop && !start_tick) begin
        case (cmd.kind)
          CMD_HEARTBEAT: begin
            online_r[cmd_idx]    <= 1'b1;
            last_seen_r[cmd_idx] <= cmd.now_ms;
          end
          CMD_STATUS: begin
            online_r[cmd_idx]    <= 1'b1;
            last_seen_r[cmd_idx] <= cmd.now_ms;
            floor_r[cmd_idx]     <= cmd.floor;
            motion_r[cmd_idx]    <= cmd.motion;
            cstate_r[cmd_idx]    <= cmd.car_mode;
          end
          CMD_HALL_UP: begin
            pend_up_r[cmd_fidx] <= 1'b1;
          end
          CMD_HALL_DOWN: begin
            pend_down_r[cmd_fidx] <= 1'b1;
          end
          default: begin
            pend_up_r <= pend_up_r;
          end
        endcase
      end
      if ((state_r == ST_EXPIRE) && expire_hit) begin
        online_r[idx_r] <= 1'b0;
        cstate_r[idx_r] <= CAR_FAULT;
      end
      if (res_push) begin
        if (call_down_r) begin
          pend_down_r[call_floor_r] <= 1'b0;
        end else begin
          pend_up_r[call_floor_r] <= 1'b0;
        end
      end
    end
  end

  // sweep datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          idx_r <= '0;
        end
        ST_EXPIRE, ST_COST: begin
          idx_r <= idx_last ? '0 : idx_r + IDX_W'(1);
        end
        default: begin
          idx_r <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start_tick) begin
      now_r <= cmd.now_ms;
    end
    if (state_r == ST_FIND) begin
      call_floor_r <= low_floor;
      call_down_r  <= !pend_up_r[low_floor];
      best_id_r    <= 4'd0;
      min_cost_r   <= NO_CAR_COST;
    end
    if ((state_r == ST_COST) && take) begin
      best_id_r  <= 4'(idx_r) + 4'd1;
      min_cost_r <= cost;
    end
  end

endmodule

>>> rtl/elevator_group_dispatcher_top.sv
// top level of the elevator group dispatcher
// a heartbeat, status or hall call request is registered in the command queue and, once the
//   back end is idle, is popped and applied to the car table or the call masks
// a tick checks silence one car per cycle, then takes the lowest pending call and, if there is
//   one, sweeps the cost one car per cycle and pushes the assignment when a car is found
// throughput: one request per cycle while in_full is low; the tick sequencer sets the rate
// reset: synchronous active-low rst_n clears queues, car table, call masks and the timeout to 1000
module elevator_group_dispatcher_top
  import egd_pkg::*;
#(
  parameter int NODE_COUNT = 8,
  parameter int TOP_FLOOR  = 31,
  parameter int CMD_DEPTH  = 4,
  parameter int RES_DEPTH  = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_node_id,
  input  logic [7:0]  in_floor,
  input  logic [1:0]  in_direction,
  input  logic [1:0]  in_car_mode,
  input  logic [31:0] in_now_ms,
  // assignment channel
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_assign_node,
  output logic [4:0]  out_assign_floor,
  output logic [1:0]  out_assign_direction,
  // heartbeat timeout register
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  logic [31:0] timeout_r;

  // front to queue
  logic cmd_push;
  cmd_t front_cmd;

  // queue to back
  logic cmd_empty;
  logic cmd_pop;
  cmd_t back_cmd;

  // back to result queue
  logic res_push;
  logic res_full;
  res_t back_res;
  res_t out_res;

  // heartbeat timeout in milliseconds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST_VAL;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // decode the request; bad car ids on heartbeats and status reports never reach the queue
  egd_front #(
    .NODE_COUNT (NODE_COUNT),
    .TOP_FLOOR  (TOP_FLOOR)
  ) u_front (
    .in_push      (in_push),
    .in_mode      (in_mode),
    .in_node_id   (in_node_id),
    .in_floor     (in_floor),
    .in_direction (in_direction),
    .in_car_mode  (in_car_mode),
    .in_now_ms    (in_now_ms),
    .cmd_push     (cmd_push),
    .cmd          (front_cmd)
  );

  // command queue decouples request arrival from tick sweeps
  egd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  // car table, call masks and the tick sequencer
  egd_back #(
    .NODE_COUNT (NODE_COUNT),
    .TOP_FLOOR  (TOP_FLOOR)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .timeout   (timeout_r),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // assignment queue; a tick only starts once there is room here
  egd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_assign_node      = out_res.assign_node;
  assign out_assign_floor     = out_res.assign_floor;
  assign out_assign_direction = out_res.assign_direction;

  // an assignment is never pushed into a full queue
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("assignment pushed into full queue");

  // commands are only taken from a non-empty queue
  a_no_cmd_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // a waiting assignment names a real car
  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_assign_node != 4'd0) && (out_assign_node <= 4'(NODE_COUNT)))
    else $error("assignment names a car outside the group");

  // a waiting assignment is an up or a down call within the building
  a_call_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_assign_direction == MOTION_UP) ||
                    (out_assign_direction == MOTION_DOWN)) &&
                   (out_assign_floor <= 5'(TOP_FLOOR)))
    else $error("assignment carries a bad call");

endmodule

>>> dv/elevator_group_dispatcher_top_test.sv
// testbench of the elevator group dispatcher: requests checked against a car table model
module elevator_group_dispatcher_top_test;
  import egd_pkg::*;

  // testbench copies of the block's default sizes
  localparam int CARS        = 8;
  localparam int TOP_FLOOR   = 31;
  // settle time after the last owed assignment; four queued ticks fit well inside it
  localparam int SETTLE_CYCLES = 120;
  // long receiver hold-off so that the result queue and then the command queue fill up
  localparam int HOLD_CYCLES   = 300;
  localparam longint RUN_LIMIT = 64'd7_200_000;

  // codes the package does not name
  localparam logic [1:0] MOTION_IDLE = 2'd0;
  localparam logic [1:0] MOTION_ODD  = 2'd3;
  localparam logic [1:0] CAR_OTHER   = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_mode = MODE_HEARTBEAT;
  logic [3:0]  in_node_id = '0;
  logic [7:0]  in_floor = '0;
  logic [1:0]  in_direction = MOTION_IDLE;
  logic [1:0]  in_car_mode = CAR_IDLE;
  logic [31:0] in_now_ms = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [3:0]  out_assign_node;
  logic [4:0]  out_assign_floor;
  logic [1:0]  out_assign_direction;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // car table and call masks as the block should hold them
  logic [31:0] timeout_ms = TIMEOUT_RST_VAL;
  logic        car_online [CARS];
  logic [31:0] car_seen   [CARS];
  logic [7:0]  car_floor  [CARS];
  logic [1:0]  car_motion [CARS];
  logic [1:0]  car_mode   [CARS];
  logic [31:0] calls_up   = '0;
  logic [31:0] calls_down = '0;

  // assignments the block still owes, oldest first
  res_t        awaited_assignments [$];
  res_t        want_res;

  int unsigned fail_count      = 0;
  int unsigned send_idle_pct   = 33;
  int unsigned recv_idle_pct   = 47;
  int unsigned pop_hold_cycles = 0;
  // simulated millisecond clock for the random traffic
  logic [31:0] clock_ms = '0;

  elevator_group_dispatcher_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_mode              (in_mode),
    .in_node_id           (in_node_id),
    .in_floor             (in_floor),
    .in_direction         (in_direction),
    .in_car_mode          (in_car_mode),
    .in_now_ms            (in_now_ms),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_assign_node      (out_assign_node),
    .out_assign_floor     (out_assign_floor),
    .out_assign_direction (out_assign_direction),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata)
  );

  always #6 clk = ~clk;

  // apply one accepted request to the car table; a tick may owe an assignment
  function automatic void predict_assignment(input logic [1:0] kind, input logic [3:0] node,
                                             input logic [7:0] floor, input logic [1:0] dir,
                                             input logic [1:0] cmode, input logic [31:0] now);
    int         i;
    int         idx;
    int         call_floor;
    int         best_car;
    logic [1:0] call_dir;
    logic [7:0] fl8;
    logic [7:0] gap;
    logic [7:0] cost;
    logic [7:0] low_cost;
    logic       away;
    res_t       res;
    if (kind == MODE_HEARTBEAT || kind == MODE_STATUS) begin
      // ids outside 1..CARS are dropped
      if (node == 4'd0 || node > CARS) return;
      idx = node - 1;
      if (kind == MODE_STATUS) begin
        car_floor[idx]  = floor;
        car_motion[idx] = dir;
        car_mode[idx]   = cmode;
      end
      car_online[idx] = 1'b1;
      car_seen[idx]   = now;
      return;
    end
    if (kind == MODE_HALL_CALL) begin
      call_floor = (floor > TOP_FLOOR) ? TOP_FLOOR : floor;
      // anything but down counts as an up call
      if (dir == MOTION_DOWN) calls_down[call_floor] = 1'b1;
      else calls_up[call_floor] = 1'b1;
      return;
    end
    // tick: silence check first, elapsed time wraps at 32 bits
    for (i = 0; i < CARS; i++) begin
      if (car_online[i] && (now - car_seen[i]) > timeout_ms) begin
        car_online[i] = 1'b0;
        car_mode[i]   = CAR_FAULT;
      end
    end
    // lowest floor wins, up before down on the same floor
    call_floor = -1;
    call_dir   = MOTION_UP;
    for (i = 0; i <= TOP_FLOOR; i++) begin
      if (call_floor < 0) begin
        if (calls_up[i]) begin
          call_floor = i;
          call_dir   = MOTION_UP;
        end else if (calls_down[i]) begin
          call_floor = i;
          call_dir   = MOTION_DOWN;
        end
      end
    end
    if (call_floor < 0) return;
    fl8      = 8'(call_floor);
    best_car = 0;
    low_cost = NO_CAR_COST;
    for (i = 0; i < CARS; i++) begin
      if (car_online[i] && car_mode[i] != CAR_FAULT) begin
        gap  = (car_floor[i] > fl8) ? car_floor[i] - fl8 : fl8 - car_floor[i];
        away = (car_motion[i] == MOTION_UP && car_floor[i] > fl8) ||
               (car_motion[i] == MOTION_DOWN && car_floor[i] < fl8);
        // eight-bit sum, so a far car moving away can wrap to a low cost
        cost = gap + ((car_mode[i] == CAR_MOVING && away) ? AWAY_PENALTY : 8'd0);
        if (cost < low_cost) begin
          low_cost = cost;
          best_car = i + 1;
        end
      end
    end
    // no car below the no-car cost: the call stays pending
    if (best_car == 0) return;
    if (call_dir == MOTION_UP) calls_up[call_floor] = 1'b0;
    else calls_down[call_floor] = 1'b0;
    res.assign_node      = 4'(best_car);
    res.assign_floor     = 5'(call_floor);
    res.assign_direction = call_dir;
    awaited_assignments.push_back(res);
  endfunction

  function automatic void reset_car_table();
    int i;
    for (i = 0; i < CARS; i++) begin
      car_online[i] = 1'b0;
      car_seen[i]   = '0;
      car_floor[i]  = '0;
      car_motion[i] = MOTION_IDLE;
      car_mode[i]   = CAR_IDLE;
    end
    calls_up   = '0;
    calls_down = '0;
    timeout_ms = TIMEOUT_RST_VAL;
  endfunction

  // offer one request, with random idle cycles first; push stays high for a following request
  task automatic send_request(input logic [1:0] kind, input logic [3:0] node,
                              input logic [7:0] floor, input logic [1:0] dir,
                              input logic [1:0] cmode, input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_mode      <= kind;
    in_node_id   <= node;
    in_floor     <= floor;
    in_direction <= dir;
    in_car_mode  <= cmode;
    in_now_ms    <= now;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_assignment(kind, node, floor, dir, cmode, now);
  endtask

  // stop offering, collect every owed assignment, then let a trailing tick finish
  task automatic settle_block();
    in_push <= 1'b0;
    while (awaited_assignments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    timeout_ms = value;
  endtask

  // mostly plausible traffic on a slowly moving clock, with stray ids, high floors and time jumps
  task automatic random_request(input int unsigned adv_small, input int unsigned adv_large);
    int unsigned pick;
    logic [1:0]  kind;
    logic [3:0]  node;
    logic [7:0]  floor;
    logic [1:0]  cmode;
    pick = $urandom_range(99);
    if (pick < 90) clock_ms += $urandom_range(adv_small);
    else if (pick < 98) clock_ms += $urandom_range(adv_large);
    else clock_ms = $urandom;
    kind  = 2'($urandom_range(3));
    node  = ($urandom_range(99) < 88) ? 4'($urandom_range(CARS, 1)) : 4'($urandom_range(15));
    floor = ($urandom_range(99) < 80) ? 8'($urandom_range(TOP_FLOOR)) : 8'($urandom_range(255));
    pick  = $urandom_range(99);
    if (pick < 40) cmode = CAR_MOVING;
    else if (pick < 70) cmode = CAR_IDLE;
    else if (pick < 85) cmode = CAR_FAULT;
    else cmode = CAR_OTHER;
    send_request(kind, node, floor, 2'($urandom_range(3)), cmode, clock_ms);
  endtask

  // stray ids, clamped floor, odd direction code, calls with no car online
  task automatic test_ignored_and_clamped();
    send_request(MODE_TICK,      4'd0,  8'd0,   MOTION_IDLE, CAR_IDLE,  32'd0);
    send_request(MODE_HEARTBEAT, 4'd0,  8'd0,   MOTION_IDLE, CAR_IDLE,  32'd0);
    send_request(MODE_HEARTBEAT, 4'd9,  8'd0,   MOTION_IDLE, CAR_IDLE,  32'd0);
    send_request(MODE_STATUS,    4'd15, 8'd255, MOTION_ODD,  CAR_OTHER, 32'hFFFF_FFFF);
    // floor 255 lands on the top floor as an up call
    send_request(MODE_HALL_CALL, 4'd0,  8'd255, MOTION_ODD,  CAR_IDLE,  32'd0);
    send_request(MODE_TICK,      4'd0,  8'd0,   MOTION_IDLE, CAR_IDLE,  32'd0);
    // odd motion code is stored but never counts as moving away
    send_request(MODE_STATUS,    4'd1,  8'd31,  MOTION_ODD,  CAR_OTHER, 32'd100);
    send_request(MODE_TICK,      4'd0,  8'd0,   MOTION_IDLE, CAR_IDLE,  32'd100);
  endtask

  // away penalty, tie on cost, faulted car skipped, up before down on one floor
  task automatic test_cost_rules();
    send_request(MODE_STATUS,    4'd2, 8'd0, MOTION_UP,   CAR_MOVING, 32'd100);
    send_request(MODE_STATUS,    4'd3, 8'd7, MOTION_UP,   CAR_MOVING, 32'd100);
    send_request(MODE_STATUS,    4'd4, 8'd9, MOTION_DOWN, CAR_MOVING, 32'd100);
    send_request(MODE_STATUS,    4'd5, 8'd5, MOTION_IDLE, CAR_FAULT,  32'd100);
    send_request(MODE_HALL_CALL, 4'd0, 8'd5, MOTION_DOWN, CAR_IDLE,   32'd100);
    send_request(MODE_HALL_CALL, 4'd0, 8'd5, MOTION_IDLE, CAR_IDLE,   32'd100);
    send_request(MODE_TICK,      4'd0, 8'd0, MOTION_IDLE, CAR_IDLE,   32'd200);
    send_request(MODE_TICK,      4'd0, 8'd0, MOTION_IDLE, CAR_IDLE,   32'd200);
  endtask

  // silence exactly at the timeout, just past it, cost wrap, no-car cost and clock wrap
  task automatic test_silence_expiry();
    send_request(MODE_STATUS,    4'd6, 8'd254, MOTION_UP,   CAR_MOVING, 32'd1100);
    send_request(MODE_HALL_CALL, 4'd0, 8'd0,   MOTION_DOWN, CAR_IDLE,   32'd1100);
    send_request(MODE_TICK,      4'd0, 8'd0,   MOTION_IDLE, CAR_IDLE,   32'd1100);
    send_request(MODE_HALL_CALL, 4'd0, 8'd0,   MOTION_DOWN, CAR_IDLE,   32'd1101);
    send_request(MODE_TICK,      4'd0, 8'd0,   MOTION_IDLE, CAR_IDLE,   32'd1101);
    send_request(MODE_STATUS,    4'd6, 8'd254, MOTION_UP,   CAR_FAULT,  32'd1101);
    // a car at floor 255 costs 255 for floor 0 and so is never chosen
    send_request(MODE_STATUS,    4'd7, 8'd255, MOTION_DOWN, CAR_MOVING, 32'd1101);
    send_request(MODE_HALL_CALL, 4'd0, 8'd0,   MOTION_UP,   CAR_IDLE,   32'd1101);
    send_request(MODE_TICK,      4'd0, 8'd0,   MOTION_IDLE, CAR_IDLE,   32'd1101);
    send_request(MODE_HEARTBEAT, 4'd8, 8'd0,   MOTION_IDLE, CAR_IDLE,   32'hFFFF_FFFF);
    send_request(MODE_TICK,      4'd0, 8'd0,   MOTION_IDLE, CAR_IDLE,   32'h0000_0010);
  endtask

  // hold the receiver off while calls and ticks keep coming, so the input backs up
  task automatic test_full_stall();
    int car;
    for (car = 1; car <= CARS; car++) begin
      send_request(MODE_STATUS, 4'(car), 8'($urandom_range(TOP_FLOOR)), MOTION_UP, CAR_IDLE,
                   clock_ms);
    end
    pop_hold_cycles = HOLD_CYCLES;
    repeat (12) begin
      send_request(MODE_HALL_CALL, 4'd0, 8'($urandom_range(TOP_FLOOR)), 2'($urandom_range(3)),
                   CAR_IDLE, clock_ms);
      send_request(MODE_TICK, 4'd0, 8'd0, MOTION_IDLE, CAR_IDLE, clock_ms);
    end
  endtask

  task automatic test_random_traffic(input logic [31:0] timeout_val, input int unsigned count,
                                     input int unsigned adv_small, input int unsigned adv_large);
    write_timeout(timeout_val);
    repeat (count) random_request(adv_small, adv_large);
  endtask

  // receiver: random pops, or a counted hold-off when one is asked for
  always @(posedge clk) begin
    if (pop_hold_cycles != 0) begin
      out_pop <= 1'b0;
      pop_hold_cycles--;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare every popped assignment with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_assignments.size() == 0) begin
        $display("%0t: unexpected assignment node %0d floor %0d direction %0d", $time,
                 out_assign_node, out_assign_floor, out_assign_direction);
        fail_count++;
      end else begin
        want_res = awaited_assignments.pop_front();
        if (out_assign_node !== want_res.assign_node) begin
          $display("%0t: assign_node expected %0d actual %0d", $time,
                   want_res.assign_node, out_assign_node);
          fail_count++;
        end
        if (out_assign_floor !== want_res.assign_floor) begin
          $display("%0t: assign_floor expected %0d actual %0d", $time,
                   want_res.assign_floor, out_assign_floor);
          fail_count++;
        end
        if (out_assign_direction !== want_res.assign_direction) begin
          $display("%0t: assign_direction expected %0d actual %0d", $time,
                   want_res.assign_direction, out_assign_direction);
          fail_count++;
        end
      end
    end
  end

  initial begin
    reset_car_table();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // sender idles a third of the time, receiver nearly half
    test_ignored_and_clamped();
    test_cost_rules();
    test_silence_expiry();
    test_random_traffic(TIMEOUT_RST_VAL, 400, 40, 1500);
    test_full_stall();
    test_random_traffic(32'd0, 150, 0, 3);
    // idling swapped between the two sides
    send_idle_pct = 47;
    recv_idle_pct = 33;
    test_random_traffic(32'hFFFF_FFFF, 350, 1000, 32'h7FFF_FFFF);
    test_random_traffic(32'($urandom_range(5000, 50)), 150, 100, 10000);
    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(32'd50, 440, 2, 100);
    settle_block();
    if (fail_count == 0) begin
      $display("[elevator_group_dispatcher_top] OK");
    end else begin
      $display("[elevator_group_dispatcher_top] ERROR");
    end
    $finish;
  end

  // watchdog for a hung handshake or a lost assignment
  initial begin
    #(RUN_LIMIT);
    $display("[elevator_group_dispatcher_top] ERROR");
    $finish;
  end

endmodule
